// ===== hw/rtl/muee_pkg.sv =====
`timescale 1ns / 1ps

package muee_pkg;

    // Sizes of the edge store and of the vertex fields
    localparam int MAX_EDGES    = 1024;
    localparam int VERTEX_LIMIT = 65536;
    localparam int CORNER_W     = 17;
    localparam int VTX_W        = 16;
    localparam int SLOT_W       = $clog2(MAX_EDGES);
    localparam int CNT_W        = $clog2(MAX_EDGES + 1);
    localparam int ENTRY_W      = 2 * VTX_W;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Edge select codes: which corner pair of the triangle is checked
    typedef enum logic [1:0] {
        SEL_AB = 2'd0,
        SEL_AC = 2'd1,
        SEL_BC = 2'd2
    } edge_sel_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EMIT = 2'd2,
        ST_NEXT = 2'd3
    } back_state_t;

    // Input word: one triangle, one-based corners
    typedef struct packed {
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
    } tri_word_t;

    // Queued triangle, zero-based vertices
    typedef struct packed {
        logic [VTX_W-1:0] vtx_a;
        logic [VTX_W-1:0] vtx_b;
        logic [VTX_W-1:0] vtx_c;
    } tri_vtx_t;

    // Output word: one new edge
    typedef struct packed {
        logic [VTX_W-1:0]  end_first;
        logic [VTX_W-1:0]  end_second;
        logic [SLOT_W-1:0] edge_slot;
        logic              dropped;
        logic              run_end;
    } edge_word_t;

    // Queue handshake between front and back
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_status_t;

endpackage

// ===== hw/rtl/muee_front.sv =====
`timescale 1ns / 1ps

module muee_front (
    input  logic                 tri_valid,
    output logic                 tri_stall,
    input  muee_pkg::tri_word_t  tri_word,
    input  muee_pkg::queue_status_t q_status,
    output logic                 q_push,
    output muee_pkg::tri_vtx_t   q_data
);

    // One-based corner to zero-based vertex, clamped at the vertex limit
    function automatic logic [muee_pkg::VTX_W-1:0] to_zero_based(
        input logic [muee_pkg::CORNER_W-1:0] raw
    );
        logic [muee_pkg::CORNER_W-1:0] dec;
        begin
            dec = raw - muee_pkg::CORNER_W'(1);
            if (raw == '0)
                to_zero_based = '0;
            else if (raw > muee_pkg::CORNER_W'(muee_pkg::VERTEX_LIMIT))
                to_zero_based = muee_pkg::VTX_W'(muee_pkg::VERTEX_LIMIT - 1);
            else
                to_zero_based = dec[muee_pkg::VTX_W-1:0];
        end
    endfunction

    // Accept whenever the queue has room
    assign tri_stall = q_status.full;
    assign q_push    = tri_valid && !q_status.full;

    assign q_data.vtx_a = to_zero_based(tri_word.corner_a);
    assign q_data.vtx_b = to_zero_based(tri_word.corner_b);
    assign q_data.vtx_c = to_zero_based(tri_word.corner_c);

endmodule

// ===== hw/rtl/muee_fifo.sv =====
`timescale 1ns / 1ps

module muee_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  muee_pkg::tri_vtx_t      push_data,
    input  logic                    pop,
    output muee_pkg::tri_vtx_t      pop_data,
    output muee_pkg::queue_status_t status
);

    muee_pkg::tri_vtx_t               slot_reg [muee_pkg::QUEUE_DEPTH];
    logic [muee_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [muee_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [muee_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;
    logic                             do_push, do_pop;

    assign status.full      = (cnt_reg == muee_pkg::QCNT_W'(muee_pkg::QUEUE_DEPTH));
    assign status.not_empty = (cnt_reg != '0);
    assign do_push          = push && !status.full;
    assign do_pop           = pop && status.not_empty;
    assign pop_data         = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == muee_pkg::QPTR_W'(muee_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + muee_pkg::QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == muee_pkg::QPTR_W'(muee_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + muee_pkg::QPTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + muee_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - muee_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/muee_back.sv =====
`timescale 1ns / 1ps

module muee_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  muee_pkg::queue_status_t q_status,
    input  muee_pkg::tri_vtx_t      q_data,
    output logic                    q_pop,
    output logic                    edge_valid,
    input  logic                    edge_stall,
    output muee_pkg::edge_word_t    edge_word
);

    // Edge store: {second, first} per entry
    logic [muee_pkg::ENTRY_W-1:0]   mem [muee_pkg::MAX_EDGES];

    muee_pkg::back_state_t          state_reg, state_next;
    muee_pkg::edge_sel_t            sel_reg, sel_next;
    muee_pkg::tri_vtx_t             vtx_reg, vtx_next;
    logic [muee_pkg::CNT_W-1:0]     idx_reg, idx_next;
    logic [muee_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           rd_pend_reg, rd_pend_next;
    logic [muee_pkg::ENTRY_W-1:0]   mem_q_reg;
    muee_pkg::edge_word_t           pend_reg, pend_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic                           out_valid_reg, out_valid_next;
    muee_pkg::edge_word_t           out_word_reg, out_word_next;

    logic [muee_pkg::VTX_W-1:0]     p, q;
    logic [muee_pkg::ENTRY_W-1:0]   fwd, rev;
    logic                           hit, full, out_free, flush_ok;
    logic                           mem_re, mem_we;

    // Current edge endpoints
    always_comb
    begin
        case (sel_reg)
            muee_pkg::SEL_AB:
            begin
                p = vtx_reg.vtx_a;
                q = vtx_reg.vtx_b;
            end
            muee_pkg::SEL_AC:
            begin
                p = vtx_reg.vtx_a;
                q = vtx_reg.vtx_c;
            end
            default:
            begin
                p = vtx_reg.vtx_b;
                q = vtx_reg.vtx_c;
            end
        endcase
    end

    assign fwd      = {q, p};
    assign rev      = {p, q};
    assign hit      = rd_pend_reg && ((mem_q_reg == fwd) || (mem_q_reg == rev));
    assign full     = (cnt_reg == muee_pkg::CNT_W'(muee_pkg::MAX_EDGES));
    assign out_free = !out_valid_reg || !edge_stall;
    assign flush_ok = !pend_valid_reg || out_free;

    assign edge_valid = out_valid_reg;
    assign edge_word  = out_word_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            muee_pkg::ST_IDLE:
                if (q_status.not_empty)
                    state_next = muee_pkg::ST_SCAN;
            muee_pkg::ST_SCAN:
                if (hit)
                    state_next = muee_pkg::ST_NEXT;
                else if (idx_reg == cnt_reg)
                    state_next = muee_pkg::ST_EMIT;
            muee_pkg::ST_EMIT:
                if (flush_ok)
                    state_next = muee_pkg::ST_NEXT;
            muee_pkg::ST_NEXT:
                if (sel_reg != muee_pkg::SEL_BC)
                    state_next = muee_pkg::ST_SCAN;
                else if (flush_ok)
                    state_next = muee_pkg::ST_IDLE;
            default:
                state_next = muee_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        sel_next        = sel_reg;
        vtx_next        = vtx_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = 1'b0;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && edge_stall;
        out_word_next   = out_word_reg;
        q_pop           = 1'b0;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        case (state_reg)
            muee_pkg::ST_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    q_pop    = 1'b1;
                    vtx_next = q_data;
                    sel_next = muee_pkg::SEL_AB;
                    idx_next = '0;
                end
            end
            // Linear search, one read per cycle, compare on the cycle after the read
            muee_pkg::ST_SCAN:
            begin
                if (!hit && (idx_reg < cnt_reg))
                begin
                    mem_re       = 1'b1;
                    idx_next     = idx_reg + muee_pkg::CNT_W'(1);
                    rd_pend_next = 1'b1;
                end
            end
            // New edge: older pending result goes out, this one is held
            muee_pkg::ST_EMIT:
            begin
                if (flush_ok)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = pend_reg;
                    end
                    pend_valid_next      = 1'b1;
                    pend_next.end_first  = p;
                    pend_next.end_second = q;
                    pend_next.run_end    = 1'b0;
                    pend_next.dropped    = full;
                    pend_next.edge_slot  = full ? '0 : cnt_reg[muee_pkg::SLOT_W-1:0];
                    if (!full)
                    begin
                        mem_we   = 1'b1;
                        cnt_next = cnt_reg + muee_pkg::CNT_W'(1);
                    end
                end
            end
            // Advance to next edge, or close the run
            muee_pkg::ST_NEXT:
            begin
                if (sel_reg != muee_pkg::SEL_BC)
                begin
                    sel_next = (sel_reg == muee_pkg::SEL_AB) ? muee_pkg::SEL_AC
                                                             : muee_pkg::SEL_BC;
                    idx_next = '0;
                end
                else if (flush_ok && pend_valid_reg)
                begin
                    out_valid_next        = 1'b1;
                    out_word_next         = pend_reg;
                    out_word_next.run_end = 1'b1;
                    pend_valid_next       = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= muee_pkg::ST_IDLE;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_pend_reg    <= rd_pend_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sel_reg      <= sel_next;
        vtx_reg      <= vtx_next;
        idx_reg      <= idx_next;
        pend_reg     <= pend_next;
        out_word_reg <= out_word_next;
    end

    // Edge store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[cnt_reg[muee_pkg::SLOT_W-1:0]] <= fwd;
        if (mem_re)
            mem_q_reg <= mem[idx_reg[muee_pkg::SLOT_W-1:0]];
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= muee_pkg::CNT_W'(muee_pkg::MAX_EDGES))
        else $error("edge count beyond table size");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !full)
        else $error("store write while table full");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == muee_pkg::ST_SCAN) |-> (idx_reg <= cnt_reg))
        else $error("search index past edge count");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (cnt_reg == $past(cnt_reg) + muee_pkg::CNT_W'(1)))
        else $error("edge count did not follow store write");

    a_drop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.dropped) |-> (out_word_reg.edge_slot == '0))
        else $error("dropped edge carries a slot");
`endif

endmodule

// ===== hw/rtl/mesh_unique_edge_extractor_top.sv =====
`timescale 1ns / 1ps

// Mesh unique edge extractor.
// tri channel: one triangle per word (corner_a/b/c, one-based indices).
//   tri_stall is high while the two-entry triangle queue is full.
// edge channel: one word per edge not seen before, with its table slot.
//   A word with dropped set came while the 1024-entry table was full and
//   was not stored. run_end marks the last word caused by a triangle; a
//   triangle whose edges are all known yields no word.
// Search: each edge is searched linearly through the stored edges, one
//   table read per cycle on the single read port, ending early on a hit.
//   The front accepts new triangles into the queue while the back is searching.
// A new edge is held one step so run_end can be set; a result appears once
//   the next new edge of the triangle is found or the triangle completes.
// Reset: the table becomes empty at once; no clearing pass is needed.
// edge_stall holds the output word and stalls the back end only when it
//   must pass on a result; the queue keeps taking triangles until it fills.

module mesh_unique_edge_extractor_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tri_valid,
    output logic                  tri_stall,
    input  muee_pkg::tri_word_t   tri_word,
    output logic                  edge_valid,
    input  logic                  edge_stall,
    output muee_pkg::edge_word_t  edge_word
);

    muee_pkg::queue_status_t  q_status;
    muee_pkg::tri_vtx_t       q_wdata, q_rdata;
    logic                     q_push, q_pop;

    // Front: corner conversion and queue write
    muee_front u_front (
        .tri_valid (tri_valid),
        .tri_stall (tri_stall),
        .tri_word  (tri_word),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    // Triangle queue between front and back
    muee_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .status    (q_status)
    );

    // Back: edge search, append and result output
    muee_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .edge_valid (edge_valid),
        .edge_stall (edge_stall),
        .edge_word  (edge_word)
    );

endmodule
